/* rtl/scaled_glyph_rectangle_generator_defines.svh */
// Assertion macros shared by the checker of the glyph rectangle generator.
`ifndef SCALED_GLYPH_RECTANGLE_GENERATOR_DEFINES_SVH
`define SCALED_GLYPH_RECTANGLE_GENERATOR_DEFINES_SVH

// Same-cycle implication, clocked on clk, disabled in reset.
`define SGR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, disabled in reset.
`define SGR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sgr_pkg.sv */
// Package: widths, glyph ROM, lookup function and control types.
`timescale 1ns / 1ps
`default_nettype none
package sgr_pkg;

    localparam int GLYPH_ADVANCE = 6;
    localparam int GLYPH_COUNT   = 48;
    localparam int GLYPH_W       = 5;
    localparam int GLYPH_H       = 7;
    localparam int CASE_FOLD     = 32;

    localparam int GLYPH_IDX_W = $clog2(GLYPH_COUNT);
    localparam int ROW_W       = $clog2(GLYPH_H);
    localparam int COL_W       = $clog2(GLYPH_W);

    localparam int CODE_W   = 8;
    localparam int COORD_W  = 16;
    localparam int SCALE_W  = 6;
    localparam int COLOUR_W = 32;
    localparam int DIM_W    = 14;
    localparam int POS_W    = 13;
    localparam int SIZE_W   = 6;
    localparam int PEN_W    = 24;
    localparam int ADV_W    = 9;
    // cell corner accumulators: pen plus a few cells, with headroom
    localparam int CX_W     = PEN_W + 2;
    localparam int CY_W     = COORD_W + 2;

    localparam logic [DIM_W-1:0] IMG_MAX      = DIM_W'(8192);
    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);
    localparam logic [PEN_W-1:0] PEN_MAX      = {1'b0, {(PEN_W-1){1'b1}}};

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    // controller states
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_WALK
    } sgr_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic advance;
        logic capture;
        logic push;
        logic push_last;
    } sgr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic cell_vis;
        logic last_cell;
        logic pend_valid;
        logic out_free;
    } sgr_status_t;

    // character codes
    localparam logic [CODE_W-1:0] CH_A_UC   = 8'h41;
    localparam logic [CODE_W-1:0] CH_Z_UC   = 8'h5A;
    localparam logic [CODE_W-1:0] CH_A_LC   = 8'h61;
    localparam logic [CODE_W-1:0] CH_Z_LC   = 8'h7A;
    localparam logic [CODE_W-1:0] CH_0      = 8'h30;
    localparam logic [CODE_W-1:0] CH_9      = 8'h39;
    localparam logic [CODE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CODE_W-1:0] CH_PERIOD = 8'h2E;
    localparam logic [CODE_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CODE_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [CODE_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CODE_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CODE_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CODE_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CODE_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CODE_W-1:0] CH_APOS   = 8'h27;
    localparam logic [CODE_W-1:0] CH_PCT    = 8'h25;

    // glyph ROM slots
    localparam logic [GLYPH_IDX_W-1:0] GI_DIGIT0   = GLYPH_IDX_W'(26);
    localparam logic [GLYPH_IDX_W-1:0] GI_SPACE    = GLYPH_IDX_W'(36);
    localparam logic [GLYPH_IDX_W-1:0] GI_PERIOD   = GLYPH_IDX_W'(37);
    localparam logic [GLYPH_IDX_W-1:0] GI_COMMA    = GLYPH_IDX_W'(38);
    localparam logic [GLYPH_IDX_W-1:0] GI_COLON    = GLYPH_IDX_W'(39);
    localparam logic [GLYPH_IDX_W-1:0] GI_MINUS    = GLYPH_IDX_W'(40);
    localparam logic [GLYPH_IDX_W-1:0] GI_PLUS     = GLYPH_IDX_W'(41);
    localparam logic [GLYPH_IDX_W-1:0] GI_SLASH    = GLYPH_IDX_W'(42);
    localparam logic [GLYPH_IDX_W-1:0] GI_LPAREN   = GLYPH_IDX_W'(43);
    localparam logic [GLYPH_IDX_W-1:0] GI_RPAREN   = GLYPH_IDX_W'(44);
    localparam logic [GLYPH_IDX_W-1:0] GI_APOS     = GLYPH_IDX_W'(45);
    localparam logic [GLYPH_IDX_W-1:0] GI_PCT      = GLYPH_IDX_W'(46);
    localparam logic [GLYPH_IDX_W-1:0] GI_QUESTION = GLYPH_IDX_W'(47);

    // 5x7 font, one entry per row, MSB is the leftmost column
    localparam logic [GLYPH_W-1:0] GLYPH_ROWS [GLYPH_COUNT][GLYPH_H] = '{
        '{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
        '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E},
        '{5'h0F, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0F},
        '{5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E},
        '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},
        '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10},
        '{5'h0E, 5'h11, 5'h10, 5'h13, 5'h11, 5'h11, 5'h0E},
        '{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
        '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F},
        '{5'h07, 5'h02, 5'h02, 5'h02, 5'h02, 5'h12, 5'h0C},
        '{5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11},
        '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
        '{5'h11, 5'h1B, 5'h15, 5'h11, 5'h11, 5'h11, 5'h11},
        '{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11},
        '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
        '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10},
        '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D},
        '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11},
        '{5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E},
        '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
        '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
        '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04},
        '{5'h11, 5'h11, 5'h11, 5'h11, 5'h15, 5'h1B, 5'h11},
        '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11},
        '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04},
        '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F},
        '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
        '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F},
        '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
        '{5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E},
        '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
        '{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E},
        '{5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
        '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
        '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
        '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C},
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C},
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C, 5'h08},
        '{5'h00, 5'h0C, 5'h0C, 5'h00, 5'h0C, 5'h0C, 5'h00},
        '{5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00},
        '{5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00},
        '{5'h01, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h10},
        '{5'h06, 5'h08, 5'h10, 5'h10, 5'h10, 5'h08, 5'h06},
        '{5'h0C, 5'h02, 5'h01, 5'h01, 5'h01, 5'h02, 5'h0C},
        '{5'h04, 5'h04, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
        '{5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h11},
        '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04}
    };

    // Map a character code to its ROM slot; lower case folds, unknown codes give '?'
    function automatic logic [GLYPH_IDX_W-1:0] glyph_index(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0]      c;
        logic [GLYPH_IDX_W-1:0] idx;
        c = code;
        if (c >= CH_A_LC && c <= CH_Z_LC)
            c = c - CODE_W'(CASE_FOLD);
        if (c >= CH_A_UC && c <= CH_Z_UC)
            idx = GLYPH_IDX_W'(c - CH_A_UC);
        else if (c >= CH_0 && c <= CH_9)
            idx = GLYPH_IDX_W'(c - CH_0) + GI_DIGIT0;
        else begin
            case (c)
                CH_SPACE:  idx = GI_SPACE;
                CH_PERIOD: idx = GI_PERIOD;
                CH_COMMA:  idx = GI_COMMA;
                CH_COLON:  idx = GI_COLON;
                CH_MINUS:  idx = GI_MINUS;
                CH_PLUS:   idx = GI_PLUS;
                CH_SLASH:  idx = GI_SLASH;
                CH_LPAREN: idx = GI_LPAREN;
                CH_RPAREN: idx = GI_RPAREN;
                CH_APOS:   idx = GI_APOS;
                CH_PCT:    idx = GI_PCT;
                default:   idx = GI_QUESTION;
            endcase
        end
        return idx;
    endfunction

endpackage
`default_nettype wire

/* rtl/sgr_if.sv */
// Stream interfaces: character transactions in, rectangle transactions out.
`timescale 1ns / 1ps
`default_nettype none
interface sgr_char_if;
    import sgr_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [CODE_W-1:0]          char_code;
    logic                       first_of_string;
    logic signed [COORD_W-1:0]  start_x;
    logic signed [COORD_W-1:0]  start_y;
    logic [SCALE_W-1:0]         scale;
    logic [COLOUR_W-1:0]        colour;

    modport source (output valid, char_code, first_of_string, start_x, start_y, scale,
                    colour, input ready);
    modport sink   (input valid, char_code, first_of_string, start_x, start_y, scale,
                    colour, output ready);
endinterface

interface sgr_rect_if;
    import sgr_pkg::*;
    logic                valid;
    logic                ready;
    logic [POS_W-1:0]    rect_x;
    logic [POS_W-1:0]    rect_y;
    logic [SIZE_W-1:0]   rect_w;
    logic [SIZE_W-1:0]   rect_h;
    logic [COLOUR_W-1:0] fill_colour;
    logic                last_of_char;

    modport source (output valid, rect_x, rect_y, rect_w, rect_h, fill_colour,
                    last_of_char, input ready);
    modport sink   (input valid, rect_x, rect_y, rect_w, rect_h, fill_colour,
                    last_of_char, output ready);
endinterface
`default_nettype wire

/* rtl/sgr_ctrl.sv */
// Controller: accepts a character, walks its cells, sequences pending and output registers.
`timescale 1ns / 1ps
`default_nettype none
module sgr_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire sgr_pkg::sgr_status_t status,
    output sgr_pkg::sgr_cmd_t        cmd
);
    import sgr_pkg::*;

    sgr_state_t state_reg, state_next;
    logic       need_push;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        need_push  = status.cell_vis && status.pend_valid;
        case (state_reg)
            ST_IDLE:
            begin
                // drain the held rectangle of the previous character as its last one
                cmd.push      = status.pend_valid && status.out_free;
                cmd.push_last = 1'b1;
                in_ready      = !status.pend_valid || status.out_free;
                cmd.load      = in_valid && in_ready;
                if (cmd.load)
                    state_next = ST_WALK;
            end
            ST_WALK:
            begin
                // a visible cell displaces the held one; wait if output is busy
                if (!need_push || status.out_free)
                begin
                    cmd.advance = 1'b1;
                    cmd.capture = status.cell_vis;
                    cmd.push    = need_push;
                    if (status.last_cell)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/sgr_datapath.sv */
// Datapath: config registers, pen, cell walker, clipping, pending and output registers.
`timescale 1ns / 1ps
`default_nettype none
module sgr_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire sgr_pkg::sgr_cmd_t                 cmd,
    output sgr_pkg::sgr_status_t                   status,
    // character payload
    input  wire logic [sgr_pkg::CODE_W-1:0]        char_code,
    input  wire logic                              first_of_string,
    input  wire logic signed [sgr_pkg::COORD_W-1:0] start_x,
    input  wire logic signed [sgr_pkg::COORD_W-1:0] start_y,
    input  wire logic [sgr_pkg::SCALE_W-1:0]       scale,
    input  wire logic [sgr_pkg::COLOUR_W-1:0]      colour,
    // configuration
    input  wire logic                              cfg_we,
    input  wire logic [sgr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [sgr_pkg::DIM_W-1:0]         cfg_data,
    // rectangle output
    output logic                                   rect_valid,
    input  wire logic                              rect_ready,
    output logic [sgr_pkg::POS_W-1:0]              rect_x,
    output logic [sgr_pkg::POS_W-1:0]              rect_y,
    output logic [sgr_pkg::SIZE_W-1:0]             rect_w,
    output logic [sgr_pkg::SIZE_W-1:0]             rect_h,
    output logic [sgr_pkg::COLOUR_W-1:0]           fill_colour,
    output logic                                   last_of_char
);
    import sgr_pkg::*;

    logic [DIM_W-1:0]          width_reg, height_reg;
    logic [DIM_W-1:0]          dim_clamped;
    logic signed [PEN_W-1:0]   pen_reg;
    logic signed [PEN_W-1:0]   pen_cur, pen_next;
    logic signed [PEN_W:0]     pen_sum;
    logic [ADV_W-1:0]          adv;

    logic signed [PEN_W-1:0]   base_x_reg;
    logic signed [CX_W-1:0]    cx_reg;
    logic signed [CY_W-1:0]    cy_reg;
    logic [SCALE_W-1:0]        scale_reg;
    logic [COLOUR_W-1:0]       colour_reg;
    logic [GLYPH_IDX_W-1:0]    glyph_reg;
    logic [ROW_W-1:0]          row_reg;
    logic [COL_W-1:0]          col_reg;

    logic signed [CX_W-1:0]    scale_x, width_x, cx_end, x0, x1, dx;
    logic signed [CY_W-1:0]    scale_y, height_y, cy_end, y0, y1, dy;
    logic                      lit, vis_x, vis_y, last_col;

    logic                      pend_valid_reg;
    logic [POS_W-1:0]          pend_x_reg, pend_y_reg;
    logic [SIZE_W-1:0]         pend_w_reg, pend_h_reg;
    logic [COLOUR_W-1:0]       pend_colour_reg;

    logic                      out_valid_reg, out_last_reg;
    logic [POS_W-1:0]          out_x_reg, out_y_reg;
    logic [SIZE_W-1:0]         out_w_reg, out_h_reg;
    logic [COLOUR_W-1:0]       out_colour_reg;

    // image size registers, values above the maximum clamp to it
    assign dim_clamped = (cfg_data > IMG_MAX) ? IMG_MAX : cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= dim_clamped;
                CFG_IMAGE_HEIGHT: height_reg <= dim_clamped;
                default:          ;
            endcase
        end
    end

    // pen of this character and saturating advance for the next one
    assign pen_cur = first_of_string
                   ? {{(PEN_W-COORD_W){start_x[COORD_W-1]}}, start_x} : pen_reg;
    assign adv     = (scale == '0) ? ADV_W'(GLYPH_ADVANCE)
                                   : ADV_W'(GLYPH_ADVANCE * scale);
    assign pen_sum = {pen_cur[PEN_W-1], pen_cur} + $signed({{(PEN_W+1-ADV_W){1'b0}}, adv});
    // advance is positive, so a sign mismatch means the sum passed the maximum
    assign pen_next = (pen_sum[PEN_W] != pen_sum[PEN_W-1]) ? PEN_MAX : pen_sum[PEN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pen_reg <= '0;
        else if (cmd.load)
            pen_reg <= pen_next;
    end

    // cell walker: corner accumulators step by scale along a row, then down
    assign last_col = (col_reg == COL_W'(GLYPH_W-1));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_x_reg <= pen_cur;
            cx_reg     <= {{(CX_W-PEN_W){pen_cur[PEN_W-1]}}, pen_cur};
            cy_reg     <= {{(CY_W-COORD_W){start_y[COORD_W-1]}}, start_y};
            scale_reg  <= scale;
            colour_reg <= colour;
            glyph_reg  <= glyph_index(char_code);
            row_reg    <= '0;
            col_reg    <= '0;
        end
        else if (cmd.advance)
        begin
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= row_reg + ROW_W'(1);
                cx_reg  <= {{(CX_W-PEN_W){base_x_reg[PEN_W-1]}}, base_x_reg};
                cy_reg  <= cy_reg + scale_y;
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
                cx_reg  <= cx_reg + scale_x;
            end
        end
    end

    // clip the current cell to the image
    assign scale_x  = $signed({{(CX_W-SCALE_W){1'b0}}, scale_reg});
    assign scale_y  = $signed({{(CY_W-SCALE_W){1'b0}}, scale_reg});
    assign width_x  = $signed({{(CX_W-DIM_W){1'b0}}, width_reg});
    assign height_y = $signed({{(CY_W-DIM_W){1'b0}}, height_reg});

    assign cx_end = cx_reg + scale_x;
    assign x0     = cx_reg[CX_W-1] ? '0 : cx_reg;
    assign x1     = (cx_end > width_x) ? width_x : cx_end;
    assign vis_x  = (x1 > x0);
    assign dx     = x1 - x0;

    assign cy_end = cy_reg + scale_y;
    assign y0     = cy_reg[CY_W-1] ? '0 : cy_reg;
    assign y1     = (cy_end > height_y) ? height_y : cy_end;
    assign vis_y  = (y1 > y0);
    assign dy     = y1 - y0;

    assign lit = GLYPH_ROWS[glyph_reg][row_reg][COL_W'(GLYPH_W-1) - col_reg];

    // pending rectangle: held until we know whether another follows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_valid_reg <= 1'b0;
        else if (cmd.capture)
            pend_valid_reg <= 1'b1;
        else if (cmd.push)
            pend_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pend_x_reg      <= x0[POS_W-1:0];
            pend_y_reg      <= y0[POS_W-1:0];
            pend_w_reg      <= dx[SIZE_W-1:0];
            pend_h_reg      <= dy[SIZE_W-1:0];
            pend_colour_reg <= colour_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.push)
            out_valid_reg <= 1'b1;
        else if (rect_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            out_x_reg      <= pend_x_reg;
            out_y_reg      <= pend_y_reg;
            out_w_reg      <= pend_w_reg;
            out_h_reg      <= pend_h_reg;
            out_colour_reg <= pend_colour_reg;
            out_last_reg   <= cmd.push_last;
        end
    end

    // status to the controller
    assign status.cell_vis   = lit && vis_x && vis_y;
    assign status.last_cell  = (row_reg == ROW_W'(GLYPH_H-1)) && last_col;
    assign status.pend_valid = pend_valid_reg;
    assign status.out_free   = !out_valid_reg || rect_ready;

    assign rect_valid   = out_valid_reg;
    assign rect_x       = out_x_reg;
    assign rect_y       = out_y_reg;
    assign rect_w       = out_w_reg;
    assign rect_h       = out_h_reg;
    assign fill_colour  = out_colour_reg;
    assign last_of_char = out_last_reg;

endmodule
`default_nettype wire

/* rtl/scaled_glyph_rectangle_generator.sv */
// Top level of the scaled 5x7 glyph rectangle generator.
// Each character transaction is looked up in a 48-glyph 5x7 font and turned into
// one filled square per lit cell, scanned row by row, clipped to the image size set
// through cfg (index 0 width, index 1 height, values above 8192 act as 8192).
// Once a character is accepted, the cell walker tests its 35 glyph cells, one cell per
// cycle unless it is stalled. The walker stalls whenever a visible cell has to
// displace the held rectangle while the output register is still occupied. Each
// visible rectangle is held one step in a pending register so the last one can be
// flagged; once the walk ends, that last rectangle moves to the output register as
// soon as it is free, and the next character is not accepted before it moves.
`timescale 1ns / 1ps
`default_nettype none
module scaled_glyph_rectangle_generator (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    sgr_char_if.sink                             char_in,
    sgr_rect_if.source                           rect_out,
    input  wire logic                            cfg_we,
    input  wire logic [sgr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [sgr_pkg::DIM_W-1:0]       cfg_data
);
    import sgr_pkg::*;

    sgr_cmd_t    cmd;
    sgr_status_t status;

    // sequencing
    sgr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (char_in.valid),
        .in_ready (char_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and storage
    sgr_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .char_code       (char_in.char_code),
        .first_of_string (char_in.first_of_string),
        .start_x         (char_in.start_x),
        .start_y         (char_in.start_y),
        .scale           (char_in.scale),
        .colour          (char_in.colour),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .rect_valid      (rect_out.valid),
        .rect_ready      (rect_out.ready),
        .rect_x          (rect_out.rect_x),
        .rect_y          (rect_out.rect_y),
        .rect_w          (rect_out.rect_w),
        .rect_h          (rect_out.rect_h),
        .fill_colour     (rect_out.fill_colour),
        .last_of_char    (rect_out.last_of_char)
    );

endmodule
`default_nettype wire

/* rtl/sgr_checker.sv */
// Port-level checker for the glyph rectangle generator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "scaled_glyph_rectangle_generator_defines.svh"
module sgr_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic [sgr_pkg::POS_W-1:0]     rect_x,
    input  wire logic [sgr_pkg::POS_W-1:0]     rect_y,
    input  wire logic [sgr_pkg::SIZE_W-1:0]    rect_w,
    input  wire logic [sgr_pkg::SIZE_W-1:0]    rect_h,
    input  wire logic [sgr_pkg::COLOUR_W-1:0]  fill_colour,
    input  wire logic                          last_of_char
);
    import sgr_pkg::*;

    localparam int RECT_BUS_W = 2 * POS_W + 2 * SIZE_W + COLOUR_W + 1;

    logic [DIM_W-1:0]      x_end, y_end;
    logic                  rect_inside;
    logic [RECT_BUS_W-1:0] rect_bus;

    assign x_end       = DIM_W'(rect_x) + DIM_W'(rect_w);
    assign y_end       = DIM_W'(rect_y) + DIM_W'(rect_h);
    assign rect_inside = (x_end <= IMG_MAX) && (y_end <= IMG_MAX);
    assign rect_bus    = {rect_x, rect_y, rect_w, rect_h, fill_colour, last_of_char};

    // one character at a time: the walker is busy right after a transaction
    `SGR_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

    // clipped rectangles are never empty
    `SGR_ASSERT_IMPL(a_rect_nonempty, out_valid, rect_w != 0 && rect_h != 0, "empty rectangle")

    // clipped rectangles stay inside the largest image
    `SGR_ASSERT_IMPL(a_rect_inside, out_valid, rect_inside, "rect off image")

    // a stalled rectangle holds
    `SGR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(rect_bus), "stalled rectangle changed")

endmodule

bind scaled_glyph_rectangle_generator sgr_checker u_sgr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (char_in.valid),
    .in_ready     (char_in.ready),
    .out_valid    (rect_out.valid),
    .out_ready    (rect_out.ready),
    .rect_x       (rect_out.rect_x),
    .rect_y       (rect_out.rect_y),
    .rect_w       (rect_out.rect_w),
    .rect_h       (rect_out.rect_h),
    .fill_colour  (rect_out.fill_colour),
    .last_of_char (rect_out.last_of_char)
);
`default_nettype wire
